@@ design/wuf_pkg.sv @@
`timescale 1ns / 1ps

package wuf_pkg;

  // number of elements in the forest
  localparam int NUM_ELEMS = 8192;

  // fixed width of element and root fields on the channels
  localparam int ELEM_W = 13;

  // internal index and size widths
  localparam int IDX_W  = $clog2(NUM_ELEMS);
  localparam int SIZE_W = $clog2(NUM_ELEMS + 1);

  // remainder unit: one compare-subtract per step against NUM_ELEMS << k
  localparam int RED_W = $clog2(ELEM_W + 1);

  function automatic int red_steps_calc();
    int n;
    n = 0;
    for (int k = 0; k <= ELEM_W; k++) begin
      if ((longint'(NUM_ELEMS) << k) <= longint'((1 << ELEM_W) - 1)) begin
        n = n + 1;
      end
    end
    return n;
  endfunction

  localparam int RED_STEPS = red_steps_calc();

  // shifted divisor for step k, only used where it fits in ELEM_W bits
  function automatic logic [ELEM_W-1:0] red_div(input logic [RED_W-1:0] k);
    longint d;
    d = longint'(NUM_ELEMS) << k;
    return ELEM_W'(d);
  endfunction

endpackage

@@ design/wuf_in_if.sv @@
`timescale 1ns / 1ps

interface wuf_in_if;
  logic                        valid;
  logic                        ready;
  logic [wuf_pkg::ELEM_W-1:0]  elem_a;
  logic [wuf_pkg::ELEM_W-1:0]  elem_b;

  modport source (output valid, output elem_a, output elem_b, input ready);
  modport sink   (input valid, input elem_a, input elem_b, output ready);
endinterface

@@ design/wuf_out_if.sv @@
`timescale 1ns / 1ps

interface wuf_out_if;
  logic                        valid;
  logic                        ready;
  logic [wuf_pkg::ELEM_W-1:0]  root_a;
  logic [wuf_pkg::ELEM_W-1:0]  root_b;
  logic                        merged;
  logic [wuf_pkg::ELEM_W-1:0]  new_root;

  modport source (output valid, output root_a, output root_b, output merged,
                  output new_root, input ready);
  modport sink   (input valid, input root_a, input root_b, input merged,
                  input new_root, output ready);
endinterface

@@ design/wuf_ram.sv @@
`timescale 1ns / 1ps

module wuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/weighted_union_find.sv @@
`timescale 1ns / 1ps

// Weighted quick-union disjoint-set engine over NUM_ELEMS elements. Each beat on
// "pairs" names two elements; the block walks both up the parent table to their
// roots, links the root of the smaller set under the larger one (the second
// root goes under the first on equal sizes), adds the sizes, and returns one
// beat on "results" with both roots, a merged flag and the surviving root.
// Indices at or above NUM_ELEMS are reduced modulo NUM_ELEMS. After reset a
// clearing pass writes identity parents and unit sizes, one entry a cycle,
// with pairs.ready low. From accept to ready again a pair occupies the block
// through the remainder steps (none when NUM_ELEMS >= 8192), the root walks of
// both elements (each tree at most log2 NUM_ELEMS deep in a weighted forest)
// and the link. The root walks make one parent-table read per level through a
// single registered read port. A finished result sits in an output register,
// so the next pair is taken while it waits.
module weighted_union_find (
  input  logic      clk,
  input  logic      rst,
  wuf_in_if.sink    pairs,
  wuf_out_if.source results
);

  localparam int IDX_W  = wuf_pkg::IDX_W;
  localparam int SIZE_W = wuf_pkg::SIZE_W;
  localparam int ELEM_W = wuf_pkg::ELEM_W;
  localparam int RED_W  = wuf_pkg::RED_W;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(wuf_pkg::NUM_ELEMS - 1);
  localparam logic [RED_W-1:0] RED_FIRST =
    RED_W'((wuf_pkg::RED_STEPS == 0) ? 0 : wuf_pkg::RED_STEPS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_REDUCE,
    S_START,
    S_WALK_A,
    S_WALK_B,
    S_LINK
  } state_t;

  state_t state;

  // control and payload registers
  logic [IDX_W-1:0]  clr;
  logic [RED_W-1:0]  k;
  logic [ELEM_W-1:0] a_red;
  logic [ELEM_W-1:0] b_red;
  logic [IDX_W-1:0]  cur;
  logic [IDX_W-1:0]  ra;
  logic [IDX_W-1:0]  rb;
  logic [SIZE_W-1:0] sa;
  logic [SIZE_W-1:0] sb;

  logic              out_valid;
  logic [ELEM_W-1:0] out_root_a;
  logic [ELEM_W-1:0] out_root_b;
  logic              out_merged;
  logic [ELEM_W-1:0] out_new_root;

  // memory ports
  logic              parent_we;
  logic [IDX_W-1:0]  parent_waddr;
  logic [IDX_W-1:0]  parent_wdata;
  logic [IDX_W-1:0]  parent_rdata;
  logic              size_we;
  logic [IDX_W-1:0]  size_waddr;
  logic [SIZE_W-1:0] size_wdata;
  logic [SIZE_W-1:0] size_rdata;
  logic [IDX_W-1:0]  raddr;

  logic [IDX_W-1:0]  a_idx;
  logic [IDX_W-1:0]  b_idx;
  logic              found;
  logic              out_free;
  logic              differ;
  logic              a_smaller;
  logic [ELEM_W-1:0] div_k;

  assign a_idx     = IDX_W'(a_red);
  assign b_idx     = IDX_W'(b_red);
  // parent data belongs to the address held in cur
  assign found     = (parent_rdata == cur);
  assign out_free  = !out_valid || results.ready;
  assign differ    = (ra != rb);
  assign a_smaller = (sa < sb);
  assign div_k     = wuf_pkg::red_div(k);

  assign pairs.ready = (state == S_IDLE);

  assign results.valid    = out_valid;
  assign results.root_a   = out_root_a;
  assign results.root_b   = out_root_b;
  assign results.merged   = out_merged;
  assign results.new_root = out_new_root;

  // read address: chase the parent straight from read data, one level a cycle;
  // both tables share it so the root's size arrives with its parent entry
  always_comb begin
    unique case (state)
      S_START:  raddr = a_idx;
      S_WALK_A: raddr = found ? b_idx : parent_rdata;
      S_WALK_B: raddr = parent_rdata;
      default:  raddr = cur;
    endcase
  end

  // write side: clearing pass, or the link at the end of a pair
  always_comb begin
    parent_we    = 1'b0;
    parent_waddr = clr;
    parent_wdata = clr;
    size_we      = 1'b0;
    size_waddr   = clr;
    size_wdata   = SIZE_W'(1);
    if (state == S_CLEAR) begin
      parent_we = 1'b1;
      size_we   = 1'b1;
    end else if (state == S_LINK && out_free && differ) begin
      parent_we    = 1'b1;
      size_we      = 1'b1;
      parent_waddr = a_smaller ? ra : rb;
      parent_wdata = a_smaller ? rb : ra;
      size_waddr   = a_smaller ? rb : ra;
      size_wdata   = SIZE_W'(sa + sb);
    end
  end

  wuf_ram #(
    .WIDTH (IDX_W),
    .DEPTH (wuf_pkg::NUM_ELEMS)
  ) u_parent (
    .clk   (clk),
    .we    (parent_we),
    .waddr (parent_waddr),
    .wdata (parent_wdata),
    .raddr (raddr),
    .rdata (parent_rdata)
  );

  wuf_ram #(
    .WIDTH (SIZE_W),
    .DEPTH (wuf_pkg::NUM_ELEMS)
  ) u_size (
    .clk   (clk),
    .we    (size_we),
    .waddr (size_waddr),
    .wdata (size_wdata),
    .raddr (raddr),
    .rdata (size_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      out_valid <= 1'b0;
    end else begin
      // result beat taken; in S_LINK the load below refills the register
      if (out_valid && results.ready && state != S_LINK) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == LAST_IDX) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (pairs.valid) begin
            a_red <= pairs.elem_a;
            b_red <= pairs.elem_b;
            k     <= RED_FIRST;
            state <= (wuf_pkg::RED_STEPS == 0) ? S_START : S_REDUCE;
          end
        end

        // restoring remainder, one shifted divisor per cycle, largest first
        S_REDUCE: begin
          if (a_red >= div_k) begin
            a_red <= a_red - div_k;
          end
          if (b_red >= div_k) begin
            b_red <= b_red - div_k;
          end
          if (k == '0) begin
            state <= S_START;
          end else begin
            k <= k - 1'b1;
          end
        end

        S_START: begin
          cur   <= a_idx;
          state <= S_WALK_A;
        end

        S_WALK_A: begin
          if (found) begin
            ra    <= cur;
            sa    <= size_rdata;
            cur   <= b_idx;
            state <= S_WALK_B;
          end else begin
            cur <= parent_rdata;
          end
        end

        S_WALK_B: begin
          if (found) begin
            rb    <= cur;
            sb    <= size_rdata;
            state <= S_LINK;
          end else begin
            cur <= parent_rdata;
          end
        end

        // link and result load happen together once the output register frees
        S_LINK: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            out_root_a   <= ELEM_W'(ra);
            out_root_b   <= ELEM_W'(rb);
            out_merged   <= differ;
            out_new_root <= (differ && a_smaller) ? ELEM_W'(rb) : ELEM_W'(ra);
            state        <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
